// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// needs clk_i and rst_ni visible in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define BDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define BDA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/bda_pkg.sv -----
// types, constants and register codes for the button debouncer with autorepeat
// no dependencies
package bda_pkg;

  localparam int unsigned NUM_BUTTONS = 5;
  localparam int unsigned NUM_AXES    = 2;
  localparam int unsigned NUM_KEYS    = NUM_BUTTONS + 2 * NUM_AXES;
  localparam int unsigned PRESS_LEVEL = 20;
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned STEP_W      = 8;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_UP       = 3'd0,
    CFG_STEP_DOWN     = 3'd1,
    CFG_HIGH_PRESS    = 3'd2,
    CFG_HIGH_RELEASE  = 3'd3,
    CFG_LOW_PRESS     = 3'd4,
    CFG_LOW_RELEASE   = 3'd5,
    CFG_REPEAT_DELAY  = 3'd6,
    CFG_REPEAT_PERIOD = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [STEP_W-1:0]      step_up;
    logic [STEP_W-1:0]      step_down;
    logic [SAMPLE_BITS-1:0] high_press_level;
    logic [SAMPLE_BITS-1:0] high_release_level;
    logic [SAMPLE_BITS-1:0] low_press_level;
    logic [SAMPLE_BITS-1:0] low_release_level;
    logic [COUNT_W-1:0]     repeat_delay;
    logic [COUNT_W-1:0]     repeat_period;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    step_up:            8'd1,
    step_down:          8'd1,
    high_press_level:   12'd3595,
    high_release_level: 12'd3095,
    low_press_level:    12'd500,
    low_release_level:  12'd1000,
    repeat_delay:       16'd100,
    repeat_period:      16'd30
  };

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] raw_buttons;
    logic [SAMPLE_BITS-1:0] axis_x;
    logic [SAMPLE_BITS-1:0] axis_y;
  } in_beat_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] held_keys;
    logic [NUM_KEYS-1:0] key_presses;
  } out_beat_t;

endpackage

// ----- hdl/bda_btn_lane.sv -----
// one push-button integrator with clamp at the press level and at zero
// depends on bda_pkg
module bda_btn_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       raw_i,
  input  logic [bda_pkg::STEP_W-1:0] step_up_i,
  input  logic [bda_pkg::STEP_W-1:0] step_down_i,
  output logic                       key_d_o,
  output logic                       key_q_o
);

  logic [bda_pkg::STEP_W-1:0] integ_q, integ_d;
  logic                       key_q, key_d;
  logic [bda_pkg::STEP_W:0]   sum;

  always_comb begin
    sum     = {1'b0, integ_q} + {1'b0, step_up_i};
    integ_d = integ_q;
    key_d   = key_q;
    if (raw_i) begin
      if (sum >= (bda_pkg::STEP_W+1)'(bda_pkg::PRESS_LEVEL)) begin
        integ_d = bda_pkg::STEP_W'(bda_pkg::PRESS_LEVEL);
        key_d   = 1'b1;
      end else begin
        integ_d = sum[bda_pkg::STEP_W-1:0];
      end
    end else begin
      if (integ_q <= step_down_i) begin
        integ_d = '0;
        key_d   = 1'b0;
      end else begin
        integ_d = integ_q - step_down_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      key_q   <= 1'b0;
    end else if (en_i) begin
      integ_q <= integ_d;
      key_q   <= key_d;
    end
  end

  assign key_d_o = key_d;
  assign key_q_o = key_q;

endmodule

// ----- hdl/bda_axis_lane.sv -----
// one joystick axis: two direction bits with press and release hysteresis
// depends on bda_pkg
module bda_axis_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic [bda_pkg::SAMPLE_BITS-1:0] sample_i,
  input  bda_pkg::cfg_t                   cfg_i,
  output logic [1:0]                      dir_d_o,
  output logic [1:0]                      dir_q_o
);

  // bit 0 high side (right or up), bit 1 low side (left or down)
  logic [1:0] dir_q, dir_d;

  always_comb begin
    dir_d = dir_q;
    if (sample_i > cfg_i.high_press_level)   dir_d[0] = 1'b1;
    if (sample_i < cfg_i.high_release_level) dir_d[0] = 1'b0;
    if (sample_i < cfg_i.low_press_level)    dir_d[1] = 1'b1;
    if (sample_i > cfg_i.low_release_level)  dir_d[1] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= '0;
    end else if (en_i) begin
      dir_q <= dir_d;
    end
  end

  assign dir_d_o = dir_d;
  assign dir_q_o = dir_q;

endmodule

// ----- hdl/bda_rpt_lane.sv -----
// autorepeat for one key: hold counter up to the delay, then a wrapping phase
// depends on bda_pkg
module bda_rpt_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        key_i,
  input  logic [bda_pkg::COUNT_W-1:0] delay_i,
  input  logic [bda_pkg::COUNT_W-1:0] period_i,
  output logic                        pulse_o
);

  logic [bda_pkg::COUNT_W-1:0] hold_q, hold_d;
  logic [bda_pkg::COUNT_W-1:0] phase_q, phase_d;
  logic [bda_pkg::COUNT_W:0]   phase_inc;

  always_comb begin
    hold_d    = hold_q;
    phase_d   = phase_q;
    pulse_o   = 1'b0;
    phase_inc = {1'b0, phase_q} + 1'b1;
    if (!key_i) begin
      hold_d  = '0;
      phase_d = '0;
    end else if (hold_q < delay_i) begin
      hold_d = hold_q + 1'b1;
      if (hold_d == delay_i) begin
        pulse_o = 1'b1;
        phase_d = '0;
      end
    end else begin
      if (phase_inc >= {1'b0, period_i}) begin
        pulse_o = 1'b1;
        phase_d = '0;
      end else begin
        phase_d = phase_inc[bda_pkg::COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= '0;
      phase_q <= '0;
    end else if (en_i) begin
      hold_q  <= hold_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ----- hdl/bda_out_queue.sv -----
// two-entry result queue: head register drives the port, tail catches a beat under stall
// depends on bda_pkg
module bda_out_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bda_pkg::out_beat_t data_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               stall_i,
  output bda_pkg::out_beat_t data_o
);

  logic [1:0]         count_q, count_d;
  bda_pkg::out_beat_t head_q, tail_q;
  logic               pop;

  assign pop     = valid_o && !stall_i;
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = head_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) count_d = count_q + 2'd1;
    if (!push_i && pop) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((count_q == 2'd0 && push_i) || (count_q == 2'd1 && push_i && pop)) begin
      head_q <= data_i;
    end else if (count_q == 2'd2 && pop) begin
      head_q <= tail_q;
    end
    if (count_q == 2'd1 && push_i && !pop) begin
      tail_q <= data_i;
    end
  end

endmodule

// ----- hdl/button_debounce_autorepeat.sv -----
// button debouncer with joystick hysteresis and autorepeat: top level
// depends on bda_pkg, bda_btn_lane, bda_axis_lane, bda_rpt_lane, bda_out_queue
//
// One input beat is one scan tick: five raw active-high button bits and two
// 12-bit joystick samples. Each button lane integrates its raw bit up by
// step_up and down by step_down, clamping at the press level and at zero; the
// debounced bit changes only when a clamp is reached. Each axis lane turns its
// sample into two direction bits with separate press and release thresholds,
// and when both hold the release wins. Nine repeat lanes, one per key, count
// how long the key has been held and pulse once at repeat_delay and then every
// repeat_period ticks. The merge stage ORs the rising edges of the debounced
// state with those pulses. Each tick gives exactly one result beat: held_keys
// and key_presses, bits 0-4 buttons, 5 right, 6 left, 7 up, 8 down.
// Throughput is one beat per clock while the output queue is not full; all lanes
// update in the accept cycle, and the result is registered in a two-entry output
// queue, so input stalls only when two results are waiting. Configuration writes
// are accepted every cycle and should be made while no tick is in flight.
module button_debounce_autorepeat (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bda_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bda_pkg::out_beat_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bda_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bda_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  bda_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bda_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (bda_pkg::cfg_idx_e'(cfg_index_i))
        bda_pkg::CFG_STEP_UP:       cfg_q.step_up <= cfg_data_i[bda_pkg::STEP_W-1:0];
        bda_pkg::CFG_STEP_DOWN:     cfg_q.step_down <= cfg_data_i[bda_pkg::STEP_W-1:0];
        bda_pkg::CFG_HIGH_PRESS:
          cfg_q.high_press_level <= cfg_data_i[bda_pkg::SAMPLE_BITS-1:0];
        bda_pkg::CFG_HIGH_RELEASE:
          cfg_q.high_release_level <= cfg_data_i[bda_pkg::SAMPLE_BITS-1:0];
        bda_pkg::CFG_LOW_PRESS:
          cfg_q.low_press_level <= cfg_data_i[bda_pkg::SAMPLE_BITS-1:0];
        bda_pkg::CFG_LOW_RELEASE:
          cfg_q.low_release_level <= cfg_data_i[bda_pkg::SAMPLE_BITS-1:0];
        bda_pkg::CFG_REPEAT_DELAY:  cfg_q.repeat_delay <= cfg_data_i;
        bda_pkg::CFG_REPEAT_PERIOD: cfg_q.repeat_period <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a tick moves every lane at once
  logic                   accept;
  logic                   queue_full;
  logic [bda_pkg::NUM_KEYS-1:0] keys_old, keys_new, pulses;
  logic [bda_pkg::SAMPLE_BITS-1:0] samples [bda_pkg::NUM_AXES];

  assign in_stall_o = queue_full;
  assign accept     = in_valid_i && !in_stall_o;
  assign samples[0] = in_data_i.axis_x;
  assign samples[1] = in_data_i.axis_y;

  // button lanes
  for (genvar b = 0; b < bda_pkg::NUM_BUTTONS; b++) begin : g_btn
    bda_btn_lane u_btn (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (accept),
      .raw_i       (in_data_i.raw_buttons[b]),
      .step_up_i   (cfg_q.step_up),
      .step_down_i (cfg_q.step_down),
      .key_d_o     (keys_new[b]),
      .key_q_o     (keys_old[b])
    );
  end

  // axis lanes: x gives right and left, y gives up and down
  for (genvar a = 0; a < bda_pkg::NUM_AXES; a++) begin : g_axis
    bda_axis_lane u_axis (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (accept),
      .sample_i (samples[a]),
      .cfg_i    (cfg_q),
      .dir_d_o  (keys_new[bda_pkg::NUM_BUTTONS + 2*a +: 2]),
      .dir_q_o  (keys_old[bda_pkg::NUM_BUTTONS + 2*a +: 2])
    );
  end

  // repeat lanes, one per key, fed by the new debounced state
  for (genvar k = 0; k < bda_pkg::NUM_KEYS; k++) begin : g_rpt
    bda_rpt_lane u_rpt (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (accept),
      .key_i    (keys_new[k]),
      .delay_i  (cfg_q.repeat_delay),
      .period_i (cfg_q.repeat_period),
      .pulse_o  (pulses[k])
    );
  end

  // merge: rising edges plus autorepeat pulses
  bda_pkg::out_beat_t result;

  always_comb begin
    result.held_keys   = keys_new;
    result.key_presses = (~keys_old & keys_new) | pulses;
  end

  bda_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (result),
    .full_o  (queue_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

// ----- hdl/bda_checker.sv -----
// port-level checks for the button debouncer, bound to the top level
// depends on bda_pkg and assert_macros.svh
`include "assert_macros.svh"

module bda_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bda_pkg::out_beat_t out_data_o
);

  logic                         out_waits;
  logic [bda_pkg::NUM_KEYS-1:0] stray_presses;

  assign out_waits     = out_valid_o && out_stall_i;
  assign stray_presses = out_data_o.key_presses & ~out_data_o.held_keys;

  // a stalled result beat stays
  `BDA_ASSERT(a_out_hold, out_waits |=> out_valid_o, "result beat dropped under stall")

  // a stalled result beat keeps its payload
  `BDA_ASSERT(a_out_stable, out_waits |=> $stable(out_data_o), "stalled payload changed")

  // a press only ever shows on a key that is held
  `BDA_ASSERT(a_press_held, out_valid_o |-> (stray_presses == '0), "press on a released key")

  // input only backs up when results are waiting
  `BDA_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> out_valid_o, "input stalled, no result waiting")

endmodule

bind button_debounce_autorepeat bda_checker u_bda_checker (.*);

// ----- test/testbench.sv -----
// self-checking testbench for button_debounce_autorepeat: scan ticks in, key reports out
// depends on bda_pkg and the button_debounce_autorepeat rtl; predicts every report itself
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bda_pkg::*;

  // key positions after the push buttons
  localparam int KEY_RIGHT   = NUM_BUTTONS;
  localparam int KEY_LEFT    = NUM_BUTTONS + 1;
  localparam int KEY_UP      = NUM_BUTTONS + 2;
  localparam int KEY_DOWN    = NUM_BUTTONS + 3;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_RUNS = 5;
  localparam int RUN_TICKS   = 350;

  // receiver stall patterns
  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE,
    RX_BURSTY
  } rx_mode_e;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  in_beat_t               in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  out_beat_t              out_data_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;

  button_debounce_autorepeat u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: own copy of the registers and of the per-key state
  // ---------------------------------------------------------------------------
  cfg_t                ctl_regs;
  logic [STEP_W-1:0]   btn_level    [NUM_BUTTONS];
  logic [NUM_KEYS-1:0] key_held;
  logic [COUNT_W-1:0]  held_ticks   [NUM_KEYS];
  logic [COUNT_W-1:0]  repeat_ticks [NUM_KEYS];

  // scan ticks waiting for the driver and key reports waiting for the rtl
  in_beat_t  pending_ticks[$];
  out_beat_t due_key_reports[$];

  int n_errors   = 0;
  int n_accepted = 0;
  int cycle_no   = 0;

  // joystick hysteresis, one axis; set first, so a release that also holds wins
  function automatic logic [NUM_KEYS-1:0] axis_keys(logic [NUM_KEYS-1:0] k,
                                                    logic [SAMPLE_BITS-1:0] s,
                                                    int hi_key, int lo_key);
    if (s > ctl_regs.high_press_level)   k[hi_key] = 1'b1;
    if (s < ctl_regs.high_release_level) k[hi_key] = 1'b0;
    if (s < ctl_regs.low_press_level)    k[lo_key] = 1'b1;
    if (s > ctl_regs.low_release_level)  k[lo_key] = 1'b0;
    return k;
  endfunction

  // one scan tick: advance the predictor and return the report it yields
  function automatic out_beat_t debounce_tick(in_beat_t b);
    logic [NUM_KEYS-1:0] prev_keys;
    logic [NUM_KEYS-1:0] keys;
    logic [NUM_KEYS-1:0] presses;
    int                  sum;
    int unsigned         phase;
    out_beat_t           r;
    prev_keys = key_held;
    keys      = key_held;
    // integrators: the debounced bit moves only on a clamp
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (b.raw_buttons[i]) begin
        sum = int'(btn_level[i]) + int'(ctl_regs.step_up);
        if (sum >= int'(PRESS_LEVEL)) begin
          sum     = int'(PRESS_LEVEL);
          keys[i] = 1'b1;
        end
        btn_level[i] = sum[STEP_W-1:0];
      end else if (btn_level[i] <= ctl_regs.step_down) begin
        btn_level[i] = '0;
        keys[i]      = 1'b0;
      end else begin
        btn_level[i] = btn_level[i] - ctl_regs.step_down;
      end
    end
    keys     = axis_keys(keys, b.axis_x, KEY_RIGHT, KEY_LEFT);
    keys     = axis_keys(keys, b.axis_y, KEY_UP, KEY_DOWN);
    key_held = keys;
    presses  = ~prev_keys & keys;
    // autorepeat: hold counter up to the delay, then a wrapping phase
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (!keys[i]) begin
        held_ticks[i]   = '0;
        repeat_ticks[i] = '0;
      end else if (held_ticks[i] < ctl_regs.repeat_delay) begin
        held_ticks[i] = held_ticks[i] + 1'b1;
        if (held_ticks[i] == ctl_regs.repeat_delay) begin
          presses[i]      = 1'b1;
          repeat_ticks[i] = '0;
        end
      end else begin
        phase = 32'(repeat_ticks[i]) + 1;
        if (phase >= 32'(ctl_regs.repeat_period)) begin
          presses[i] = 1'b1;
          phase      = 0;
        end
        repeat_ticks[i] = phase[COUNT_W-1:0];
      end
    end
    r.held_keys   = keys;
    r.key_presses = presses;
    return r;
  endfunction

  function automatic void flag_error(string what, logic [NUM_KEYS-1:0] want,
                                     logic [NUM_KEYS-1:0] got);
    n_errors++;
    if (n_errors <= 10)
      $display("%0t ns: %s mismatch, expected %03h got %03h", $time, what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of beats from the pending queue with random gaps between
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin : tick_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      n_accepted <= 0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      // beat taken at this edge: predict its report right away
      if (in_valid_i) begin
        due_key_reports.push_back(debounce_tick(in_data_i));
        n_accepted <= n_accepted + 1;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_ticks.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // end of a burst: pick the next burst and the gap before it
          burst_left = $urandom_range(1, 48);
          case ($urandom_range(0, 5))
            0, 1:    gap_left = 0;
            2, 3, 4: gap_left = $urandom_range(1, 6);
            default: gap_left = $urandom_range(7, 24);
          endcase
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // long receiver hold-off so the output queue fills and the input stalls
  // ---------------------------------------------------------------------------
  logic hold_off = 1'b0;
  int   hold_left;
  int   next_hold_at;

  always @(posedge clk_i or negedge rst_ni) begin : hold_off_timer
    if (!rst_ni) begin
      hold_off     <= 1'b0;
      hold_left    = 0;
      next_hold_at = 400;
    end else if (hold_left > 0) begin
      hold_left--;
      hold_off <= (hold_left != 0);
    end else if (n_accepted >= next_hold_at) begin
      hold_left    = $urandom_range(150, 400);
      hold_off     <= 1'b1;
      next_hold_at += 600;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check each report beat, then pick the stall for the next cycle
  // ---------------------------------------------------------------------------
  rx_mode_e rx_mode;
  int       rx_left;

  always @(posedge clk_i or negedge rst_ni) begin : report_monitor
    out_beat_t want;
    logic      stall_now;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_mode     = RX_FREE;
      rx_left     = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_key_reports.size() == 0) begin
          flag_error("unexpected report, held_keys", '0, out_data_o.held_keys);
        end else begin
          want = due_key_reports.pop_front();
          if (out_data_o.held_keys !== want.held_keys)
            flag_error("held_keys", want.held_keys, out_data_o.held_keys);
          if (out_data_o.key_presses !== want.key_presses)
            flag_error("key_presses", want.key_presses, out_data_o.key_presses);
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 4));
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_LIGHT:  stall_now = ($urandom_range(0, 3) == 0);
        RX_HEAVY:  stall_now = ($urandom_range(0, 3) != 0);
        RX_TOGGLE: stall_now = ~out_stall_i;
        RX_BURSTY: stall_now = (rx_left % 8) < 3;
        default:   stall_now = 1'b0;
      endcase
      out_stall_i <= stall_now || hold_off;
    end
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin : watchdog
    cycle_no++;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // register writes, only while nothing is in flight
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_STEP_UP:       ctl_regs.step_up            = val[STEP_W-1:0];
      CFG_STEP_DOWN:     ctl_regs.step_down          = val[STEP_W-1:0];
      CFG_HIGH_PRESS:    ctl_regs.high_press_level   = val[SAMPLE_BITS-1:0];
      CFG_HIGH_RELEASE:  ctl_regs.high_release_level = val[SAMPLE_BITS-1:0];
      CFG_LOW_PRESS:     ctl_regs.low_press_level    = val[SAMPLE_BITS-1:0];
      CFG_LOW_RELEASE:   ctl_regs.low_release_level  = val[SAMPLE_BITS-1:0];
      CFG_REPEAT_DELAY:  ctl_regs.repeat_delay       = val[COUNT_W-1:0];
      CFG_REPEAT_PERIOD: ctl_regs.repeat_period      = val[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(cfg_t c);
    write_reg(CFG_STEP_UP,       CFG_DATA_W'(c.step_up));
    write_reg(CFG_STEP_DOWN,     CFG_DATA_W'(c.step_down));
    write_reg(CFG_HIGH_PRESS,    CFG_DATA_W'(c.high_press_level));
    write_reg(CFG_HIGH_RELEASE,  CFG_DATA_W'(c.high_release_level));
    write_reg(CFG_LOW_PRESS,     CFG_DATA_W'(c.low_press_level));
    write_reg(CFG_LOW_RELEASE,   CFG_DATA_W'(c.low_release_level));
    write_reg(CFG_REPEAT_DELAY,  c.repeat_delay);
    write_reg(CFG_REPEAT_PERIOD, c.repeat_period);
  endtask

  // wait until every tick went in and every report came out
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || due_key_reports.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_tick(logic [NUM_BUTTONS-1:0] raw, int x, int y);
    in_beat_t b;
    b.raw_buttons = raw;
    b.axis_x      = x[SAMPLE_BITS-1:0];
    b.axis_y      = y[SAMPLE_BITS-1:0];
    pending_ticks.push_back(b);
  endtask

  // ---------------------------------------------------------------------------
  // random stimulus: held buttons with bounce, sticky joystick positions
  // ---------------------------------------------------------------------------
  logic [NUM_BUTTONS-1:0] scene_raw;
  int                     raw_run;
  logic [SAMPLE_BITS-1:0] ax_val;
  logic [SAMPLE_BITS-1:0] ay_val;
  int                     ax_run;
  int                     ay_run;

  // joystick sample, mostly around the current thresholds
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int s;
    case ($urandom_range(0, 6))
      0:       s = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
      1:       s = int'(ctl_regs.high_press_level) + int'($urandom_range(0, 4)) - 2;
      2:       s = int'(ctl_regs.high_release_level) + int'($urandom_range(0, 4)) - 2;
      3:       s = int'(ctl_regs.low_press_level) + int'($urandom_range(0, 4)) - 2;
      4:       s = int'(ctl_regs.low_release_level) + int'($urandom_range(0, 4)) - 2;
      default: s = int'($urandom_range(0, SAMPLE_MAX));
    endcase
    if (s < 0)          s = 0;
    if (s > SAMPLE_MAX) s = SAMPLE_MAX;
    return s[SAMPLE_BITS-1:0];
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.step_up            = STEP_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                               : $urandom_range(1, 8));
    c.step_down          = STEP_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                               : $urandom_range(1, 8));
    c.high_press_level   = SAMPLE_BITS'($urandom_range(2048, SAMPLE_MAX));
    c.high_release_level = SAMPLE_BITS'($urandom_range(1024, c.high_press_level));
    c.low_press_level    = SAMPLE_BITS'($urandom_range(0, 2047));
    c.low_release_level  = SAMPLE_BITS'($urandom_range(c.low_press_level, 3071));
    c.repeat_delay       = COUNT_W'($urandom_range(1, 40));
    c.repeat_period      = COUNT_W'($urandom_range(1, 12));
    return c;
  endfunction

  task automatic queue_scan_run(int n);
    in_beat_t b;
    for (int i = 0; i < n; i++) begin
      // buttons stay put for a run, some runs long enough for autorepeat
      if (raw_run == 0) begin
        scene_raw = NUM_BUTTONS'($urandom_range(0, (1 << NUM_BUTTONS) - 1));
        raw_run   = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 40);
      end else begin
        raw_run--;
      end
      if (ax_run == 0) begin
        ax_val = pick_sample();
        ax_run = $urandom_range(1, 40);
      end else begin
        ax_run--;
      end
      if (ay_run == 0) begin
        ay_val = pick_sample();
        ay_run = $urandom_range(1, 40);
      end else begin
        ay_run--;
      end
      b.raw_buttons = scene_raw;
      b.axis_x      = ax_val;
      b.axis_y      = ay_val;
      case ($urandom_range(0, 15))
        0: begin
          // contact bounce on one button
          b.raw_buttons[$urandom_range(0, NUM_BUTTONS - 1)] ^= 1'b1;
        end
        1: begin
          // plain noise
          b.raw_buttons = NUM_BUTTONS'($urandom_range(0, (1 << NUM_BUTTONS) - 1));
          b.axis_x      = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
          b.axis_y      = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        end
        default: ;
      endcase
      pending_ticks.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : test_sequence
    cfg_t next_cfg;
    ctl_regs = CFG_RESET;
    key_held = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) btn_level[i] = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      held_ticks[i]   = '0;
      repeat_ticks[i] = '0;
    end
    scene_raw = '0;
    raw_run   = 0;
    ax_val    = '0;
    ay_val    = '0;
    ax_run    = 0;
    ay_run    = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: field extremes and samples right at each threshold
    @(negedge clk_i);
    queue_tick(5'h1f, 0, SAMPLE_MAX);
    queue_tick(5'h00, SAMPLE_MAX, 0);
    queue_tick(5'h15, 3596, 499);
    queue_tick(5'h0a, 3595, 500);
    queue_tick(5'h00, 3094, 1001);
    queue_tick(5'h00, 3095, 1000);
    wait_idle();

    // full steps, zero repeat delay and zero period: pulse on every held tick
    write_reg(CFG_STEP_UP, 16'd255);
    write_reg(CFG_STEP_DOWN, 16'd255);
    write_reg(CFG_REPEAT_DELAY, 16'd0);
    write_reg(CFG_REPEAT_PERIOD, 16'd0);
    @(negedge clk_i);
    repeat (3) queue_tick(5'h1f, 2048, 2048);
    queue_tick(5'h00, 2048, 2048);
    queue_tick(5'h11, 2048, 2048);
    wait_idle();

    // zero steps freeze the integrators; overlapping thresholds let release win
    load_cfg('{8'd0, 8'd0, 12'd100, 12'd200, 12'd3000, 12'd2000, 16'd5, 16'd3});
    @(negedge clk_i);
    repeat (7) queue_tick(5'h11, 150, 2500);
    queue_tick(5'h00, 150, 2500);
    wait_idle();

    // long delay, then lowered below the running hold count
    load_cfg('{8'd1, 8'd1, 12'd3595, 12'd3095, 12'd500, 12'd1000, 16'd65535, 16'd2});
    @(negedge clk_i);
    repeat (6) queue_tick(5'h00, SAMPLE_MAX, 2048);
    wait_idle();
    write_reg(CFG_REPEAT_DELAY, 16'd2);
    @(negedge clk_i);
    repeat (3) queue_tick(5'h00, SAMPLE_MAX, 2048);
    wait_idle();

    // random runs under reset, extreme and random settings
    for (int run = 0; run < RANDOM_RUNS; run++) begin
      case (run)
        0:       next_cfg = CFG_RESET;
        1:       next_cfg = '{8'd255, 8'd1, 12'd0, 12'd0, 12'd4095, 12'd4095, 16'd1, 16'd1};
        2:       next_cfg = '{8'd1, 8'd255, 12'd4095, 12'd4095, 12'd0, 12'd0,
                              16'd65535, 16'd65535};
        default: next_cfg = random_cfg();
      endcase
      load_cfg(next_cfg);
      @(negedge clk_i);
      queue_scan_run(RUN_TICKS);
      wait_idle();
    end

    // drain, then a short tail to catch stray reports
    repeat (16) @(posedge clk_i);
    if (due_key_reports.size() != 0) begin
      n_errors++;
      $display("%0d key reports never arrived", due_key_reports.size());
    end
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
